@@ src/lqe_pkg.sv @@
// shared constants for the link quality estimator
package lqe_pkg;

    localparam int WINDOW_DEF = 100;

    localparam logic [52:0] BW_NUM = 53'd5260239168570601;
    localparam int BW_NUM_W = 53;

    localparam logic [15:0] ALPHA_SHORT_RST = 16'd13107;
    localparam logic [15:0] ALPHA_LONG_RST  = 16'd3277;
    localparam logic [7:0]  FAIL_THR_RST    = 8'd3;
    localparam logic [15:0] LOSS_FLOOR_RST  = 16'd655;

    localparam logic [7:0] CFG_ALPHA_SHORT = 8'd0;
    localparam logic [7:0] CFG_ALPHA_LONG  = 8'd1;
    localparam logic [7:0] CFG_FAIL_THR    = 8'd2;
    localparam logic [7:0] CFG_LOSS_FLOOR  = 8'd3;

    localparam logic OP_REPLY   = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam int DIV_W  = 64;
    localparam int SQ_W   = 50;
    localparam int ROOT_W = 25;
    localparam int MC_W   = 42;
    localparam int MP_W   = 25;
    localparam int PR_W   = 67;
    localparam int OUT_W  = 248;

    typedef struct packed {
        logic       start;
        logic [6:0] steps;
    } t_unit_cmd;

endpackage

@@ src/lqe_ram.sv @@
// generic single-port-write ram with registered read
module lqe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/lqe_mul.sv @@
// bit-serial shift-add multiplier, signed multiplicand, unsigned multiplier
module lqe_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lqe_pkg::t_unit_cmd                i_cmd,
    input  logic signed [lqe_pkg::MC_W-1:0]   i_mc,
    input  logic [lqe_pkg::MP_W-1:0]          i_mp,
    output logic                              o_done,
    output logic signed [lqe_pkg::PR_W-1:0]   o_prod
);
    logic signed [lqe_pkg::PR_W-1:0] r_mc;
    logic signed [lqe_pkg::PR_W-1:0] r_acc;
    logic [lqe_pkg::MP_W-1:0]        r_mp;
    logic [6:0]                      r_cnt;
    logic                            r_busy;
    logic                            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mc  <= lqe_pkg::PR_W'(i_mc);
            r_mp  <= i_mp;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc <<< 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ src/lqe_div.sv @@
// restoring divider, one quotient bit per cycle, dividend given left aligned
module lqe_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lqe_pkg::t_unit_cmd           i_cmd,
    input  logic [lqe_pkg::DIV_W-1:0]    i_dvd,
    input  logic [lqe_pkg::DIV_W-1:0]    i_dvs,
    output logic                         o_done,
    output logic [lqe_pkg::DIV_W-1:0]    o_quo
);
    logic [lqe_pkg::DIV_W:0]   r_rem;
    logic [lqe_pkg::DIV_W-1:0] r_dvd;
    logic [lqe_pkg::DIV_W-1:0] r_dvs;
    logic [lqe_pkg::DIV_W-1:0] r_quo;
    logic [6:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [lqe_pkg::DIV_W:0]   rem_sh;
    logic [lqe_pkg::DIV_W:0]   diff;
    logic                      ge;

    assign rem_sh = {r_rem[lqe_pkg::DIV_W-1:0], r_dvd[lqe_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[lqe_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ src/lqe_sqrt.sv @@
// digit-by-digit integer square root, two radicand bits per cycle
module lqe_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lqe_pkg::SQ_W-1:0]      i_x,
    output logic                          o_done,
    output logic [lqe_pkg::ROOT_W-1:0]    o_root
);
    localparam int REM_W = lqe_pkg::ROOT_W + 3;

    logic [lqe_pkg::SQ_W-1:0]   r_x;
    logic [REM_W-1:0]           r_rem;
    logic [lqe_pkg::ROOT_W-1:0] r_root;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [REM_W-1:0]           rem_sh;
    logic [REM_W-1:0]           trial;
    logic                       ge;

    assign rem_sh = {r_rem[REM_W-3:0], r_x[lqe_pkg::SQ_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(lqe_pkg::ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[lqe_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ src/link_quality_estimator.sv @@
// link quality estimator top level: sequencer, state and result register
// one item at a time; the work per item is set by the serial units: WINDOW count width + 32
// divide steps and 25 root steps for the window loss, three 16-step ewma multiplies, then
// per score 25 root, 25 multiply, 53 divide
// the result waits in an output register; the next word is taken once the work is done
// reset (synchronous, active low) clears all but the datapath regs, loads register defaults
module link_quality_estimator #(
    parameter int WINDOW = lqe_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,  // rtt_us
    input  logic                        i_s_tuser,  // opcode
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // link_status, failure_count, fast_probe, stats_valid, short_rtt_us, short_rtt_min_us,
    // short_rtt_max_us, short_loss_q16, short_bw_score, long_rtt_us, long_loss_q16,
    // long_bw_score, zero pad
    output logic [lqe_pkg::OUT_W-1:0]   o_m_tdata,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [7:0]                  i_cfg_addr,
    input  logic [15:0]                 i_cfg_data
);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = $clog2(WINDOW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WIN  = 4'd1;
    localparam logic [3:0] S_WDIV = 4'd2;
    localparam logic [3:0] S_WSQ  = 4'd3;
    localparam logic [3:0] S_SEW  = 4'd4;
    localparam logic [3:0] S_LEW  = 4'd5;
    localparam logic [3:0] S_LLS  = 4'd6;
    localparam logic [3:0] S_SSQ  = 4'd7;
    localparam logic [3:0] S_SMU  = 4'd8;
    localparam logic [3:0] S_SDV  = 4'd9;
    localparam logic [3:0] S_LSQ  = 4'd10;
    localparam logic [3:0] S_LMU  = 4'd11;
    localparam logic [3:0] S_LDV  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]  r_state, n_state;
    logic        r_go, n_go;
    logic        r_op;
    logic [31:0] r_rtt;
    logic [15:0] r_alpha_s, r_alpha_l, r_floor;
    logic [7:0]  r_thr;
    logic [CW-1:0] r_recv, n_recv, r_seen, n_seen;
    logic [SW-1:0] r_slot, n_slot;
    logic [15:0] r_fail, n_fail;
    logic        r_fast, n_fast, r_have, n_have, r_status, n_status;
    logic [39:0] r_savg, n_savg, r_lavg, n_lavg;
    logic [31:0] r_slow, n_slow, r_shigh, n_shigh;
    logic [16:0] r_sloss, n_sloss, r_lloss, n_lloss;
    logic [32:0] r_q, n_q;
    logic [lqe_pkg::ROOT_W-1:0] r_root, n_root;
    logic [63:0] r_d, n_d;
    logic [31:0] r_sbw, n_sbw, r_lbw, n_lbw;
    logic        r_ovalid;
    logic [lqe_pkg::OUT_W-1:0] r_odata;

    logic        ram_rdata;
    logic        ram_we;
    lqe_pkg::t_unit_cmd div_cmd, mul_cmd;
    logic [63:0] div_dvd, div_dvs, div_quo;
    logic        div_done, mul_done, sq_done, sq_start;
    logic signed [lqe_pkg::MC_W-1:0] mul_mc;
    logic [lqe_pkg::MP_W-1:0] mul_mp;
    logic signed [lqe_pkg::PR_W-1:0] mul_p, ewma_t;
    logic [lqe_pkg::SQ_W-1:0] sq_x;
    logic [lqe_pkg::ROOT_W-1:0] sq_root;
    logic [39:0] x_rtt, ew_x, ew_avg, ew_new;
    logic [16:0] l_short, l_long;
    logic [31:0] score;
    logic        in_acc, out_load;

    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign x_rtt       = {r_rtt, 8'd0};
    assign l_short     = (r_sloss < {1'b0, r_floor}) ? {1'b0, r_floor} : r_sloss;
    assign l_long      = (r_lloss < {1'b0, r_floor}) ? {1'b0, r_floor} : r_lloss;
    assign score       = (|div_quo[52:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
    assign ewma_t      = (mul_p + lqe_pkg::PR_W'(32768)) >>> 16;
    assign ew_new      = ew_avg + ewma_t[39:0];
    assign ram_we      = (r_state == S_WIN);

    lqe_ram #(.WIDTH(1), .DEPTH(WINDOW)) u_win (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_op == lqe_pkg::OP_REPLY),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // unit operand selection
    always_comb begin
        div_cmd.start = r_go && (r_state == S_WDIV || r_state == S_SDV || r_state == S_LDV);
        mul_cmd.start = r_go && (r_state == S_SEW || r_state == S_LEW || r_state == S_LLS ||
                                 r_state == S_SMU || r_state == S_LMU);
        sq_start      = r_go && (r_state == S_WSQ || r_state == S_SSQ || r_state == S_LSQ);
        if (r_state == S_WDIV) begin
            div_dvd       = 64'(r_recv) << (64 - CW);
            div_dvs       = 64'(r_seen);
            div_cmd.steps = 7'(CW + 32);
        end else begin
            div_dvd       = {lqe_pkg::BW_NUM, 11'd0};
            div_dvs       = r_d;
            div_cmd.steps = 7'(lqe_pkg::BW_NUM_W);
        end
        case (r_state)
            S_WSQ:   sq_x = lqe_pkg::SQ_W'(r_q);
            S_SSQ:   sq_x = lqe_pkg::SQ_W'({l_short, 32'd0});
            default: sq_x = lqe_pkg::SQ_W'({l_long, 32'd0});
        endcase
        case (r_state)
            S_SEW: begin
                ew_x = x_rtt;
                ew_avg = r_savg;
            end
            S_LEW: begin
                ew_x = x_rtt;
                ew_avg = r_lavg;
            end
            default: begin
                ew_x = 40'(r_sloss);
                ew_avg = 40'(r_lloss);
            end
        endcase
        case (r_state)
            S_SMU: begin
                mul_mc = lqe_pkg::MC_W'(r_savg);
                mul_mp = r_root;
                mul_cmd.steps = 7'(lqe_pkg::MP_W);
            end
            S_LMU: begin
                mul_mc = lqe_pkg::MC_W'(r_lavg);
                mul_mp = r_root;
                mul_cmd.steps = 7'(lqe_pkg::MP_W);
            end
            S_SEW: begin
                mul_mc = $signed({2'b00, ew_x} - {2'b00, ew_avg});
                mul_mp = lqe_pkg::MP_W'(r_alpha_s);
                mul_cmd.steps = 7'd16;
            end
            default: begin
                mul_mc = $signed({2'b00, ew_x} - {2'b00, ew_avg});
                mul_mp = lqe_pkg::MP_W'(r_alpha_l);
                mul_cmd.steps = 7'd16;
            end
        endcase
    end

    lqe_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cmd (div_cmd),
        .i_dvd (div_dvd), .i_dvs (div_dvs), .o_done (div_done), .o_quo (div_quo)
    );

    lqe_mul u_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cmd (mul_cmd),
        .i_mc (mul_mc), .i_mp (mul_mp), .o_done (mul_done), .o_prod (mul_p)
    );

    lqe_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (sq_start),
        .i_x (sq_x), .o_done (sq_done), .o_root (sq_root)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        n_recv   = r_recv;
        n_seen   = r_seen;
        n_slot   = r_slot;
        n_fail   = r_fail;
        n_fast   = r_fast;
        n_have   = r_have;
        n_status = r_status;
        n_savg   = r_savg;
        n_lavg   = r_lavg;
        n_slow   = r_slow;
        n_shigh  = r_shigh;
        n_sloss  = r_sloss;
        n_lloss  = r_lloss;
        n_q      = r_q;
        n_root   = r_root;
        n_d      = r_d;
        n_sbw    = r_sbw;
        n_lbw    = r_lbw;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                if (r_seen >= CW'(WINDOW)) begin
                    n_recv = r_recv - CW'(ram_rdata);
                end else begin
                    n_seen = r_seen + CW'(1);
                end
                if (r_op == lqe_pkg::OP_REPLY) begin
                    n_recv = n_recv + CW'(1);
                    n_fail = '0;
                    n_fast = 1'b0;
                    n_status = 1'b0;
                    if (!r_have) begin
                        n_slow = r_rtt;
                        n_shigh = r_rtt;
                    end else begin
                        if (r_rtt < r_slow) n_slow = r_rtt;
                        if (r_rtt > r_shigh) n_shigh = r_rtt;
                    end
                end else begin
                    if (r_fail != 16'hFFFF) n_fail = r_fail + 16'd1;
                    n_status = 1'b0;
                    if (n_fail >= 16'(r_thr)) begin
                        n_fast = 1'b1;
                        n_status = 1'b1;
                    end
                end
                n_slot  = (r_slot == SW'(WINDOW - 1)) ? '0 : r_slot + SW'(1);
                n_state = S_WDIV;
                n_go    = 1'b1;
            end
            S_WDIV: begin
                if (div_done) begin
                    n_q = div_quo[32:0];
                    n_state = S_WSQ;
                    n_go = 1'b1;
                end
            end
            S_WSQ: begin
                if (sq_done) begin
                    n_sloss = 17'(18'd65536 - 18'(sq_root));
                    n_state = S_SEW;
                    n_go = 1'b1;
                end
            end
            S_SEW: begin
                if (mul_done) begin
                    if (r_op == lqe_pkg::OP_REPLY) n_savg = r_have ? ew_new : x_rtt;
                    n_state = S_LEW;
                    n_go = 1'b1;
                end
            end
            S_LEW: begin
                if (mul_done) begin
                    if (r_op == lqe_pkg::OP_REPLY) n_lavg = r_have ? ew_new : x_rtt;
                    n_state = S_LLS;
                    n_go = 1'b1;
                end
            end
            S_LLS: begin
                if (mul_done) begin
                    if (r_op == lqe_pkg::OP_REPLY) begin
                        n_lloss = r_have ? ew_new[16:0] : r_sloss;
                        n_have = 1'b1;
                    end
                    n_state = S_SSQ;
                    n_go = 1'b1;
                end
            end
            S_SSQ, S_LSQ: begin
                if (sq_done) begin
                    n_root = sq_root;
                    n_state = (r_state == S_SSQ) ? S_SMU : S_LMU;
                    n_go = 1'b1;
                end
            end
            S_SMU, S_LMU: begin
                if (mul_done) begin
                    n_d = mul_p[63:0];
                    n_state = (r_state == S_SMU) ? S_SDV : S_LDV;
                    n_go = 1'b1;
                end
            end
            S_SDV: begin
                if (div_done) begin
                    n_sbw = (!r_have || r_savg == '0) ? '0 : score;
                    n_state = S_LSQ;
                    n_go = 1'b1;
                end
            end
            S_LDV: begin
                if (div_done) begin
                    n_lbw = (!r_have || r_lavg == '0) ? '0 : score;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_recv    <= '0;
            r_seen    <= '0;
            r_slot    <= '0;
            r_fail    <= '0;
            r_fast    <= 1'b0;
            r_have    <= 1'b0;
            r_status  <= 1'b0;
            r_savg    <= '0;
            r_lavg    <= '0;
            r_slow    <= '0;
            r_shigh   <= '0;
            r_lloss   <= '0;
            r_ovalid  <= 1'b0;
            r_alpha_s <= lqe_pkg::ALPHA_SHORT_RST;
            r_alpha_l <= lqe_pkg::ALPHA_LONG_RST;
            r_thr     <= lqe_pkg::FAIL_THR_RST;
            r_floor   <= lqe_pkg::LOSS_FLOOR_RST;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_recv   <= n_recv;
            r_seen   <= n_seen;
            r_slot   <= n_slot;
            r_fail   <= n_fail;
            r_fast   <= n_fast;
            r_have   <= n_have;
            r_status <= n_status;
            r_savg   <= n_savg;
            r_lavg   <= n_lavg;
            r_slow   <= n_slow;
            r_shigh  <= n_shigh;
            r_lloss  <= n_lloss;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    lqe_pkg::CFG_ALPHA_SHORT: r_alpha_s <= i_cfg_data;
                    lqe_pkg::CFG_ALPHA_LONG:  r_alpha_l <= i_cfg_data;
                    lqe_pkg::CFG_FAIL_THR:    r_thr     <= i_cfg_data[7:0];
                    lqe_pkg::CFG_LOSS_FLOOR:  r_floor   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_s_tuser;
            r_rtt <= i_s_tdata;
        end
        r_sloss <= n_sloss;
        r_q     <= n_q;
        r_root  <= n_root;
        r_d     <= n_d;
        r_sbw   <= n_sbw;
        r_lbw   <= n_lbw;
        if (out_load) begin
            r_odata <= {3'd0, r_lbw, r_lloss, r_lavg[39:8], r_sbw, r_sloss,
                        r_shigh, r_slow, r_savg[39:8], r_have, r_fast, r_fail, r_status};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
endmodule

@@ src/lqe_checker.sv @@
// port-level checks for the link quality estimator, bound to the top level
module lqe_props (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [lqe_pkg::OUT_W-1:0] o_m_tdata
);
    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed under stall");

    // one item in flight
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // no rtt, bandwidth or long loss statistics before the first reply
    a_nostats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[18] |->
            o_m_tdata[114:19] == '0 && o_m_tdata[244:164] == '0 && o_m_tdata[163:132] == '0)
        else $error("statistics shown without a reply");

    // degraded status implies fast probing and a nonzero failure count
    a_degraded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[17] && o_m_tdata[16:1] != '0)
        else $error("degraded without fast mode");

    // window loss never above one
    a_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[131] |-> o_m_tdata[130:115] == '0)
        else $error("window loss out of range");
endmodule

bind link_quality_estimator lqe_props u_lqe_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
